/* hdl/ipat_pkg.sv */
// Shared types, character codes and byte helpers for the address text parser.
`default_nettype none

package ipat_pkg;

  typedef logic [7:0] bytes_t [16];

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X_LC  = 8'h78;
  localparam logic [7:0] CH_X_UC  = 8'h58;
  localparam logic [7:0] CH_A_LC  = 8'h61;
  localparam logic [7:0] CH_F_LC  = 8'h66;
  localparam logic [7:0] CH_A_UC  = 8'h41;
  localparam logic [7:0] CH_F_UC  = 8'h46;

  localparam logic [4:0] BYTE_END      = 5'd16;
  localparam logic [4:0] HEX_COUNT_MAX = 5'd31;
  localparam logic [7:0] BYTE_ONES     = 8'hff;

  // bit 4: character is a hex digit, bits 3:0: its value
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
      return {1'b1, v[3:0]};
    end
    if (c >= CH_A_LC && c <= CH_F_LC) begin
      v = c - CH_A_LC + 8'd10;
      return {1'b1, v[3:0]};
    end
    if (c >= CH_A_UC && c <= CH_F_UC) begin
      v = c - CH_A_UC + 8'd10;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic bytes_t store_octet(bytes_t a, logic [4:0] pos, logic [2:0] cnt,
                                         logic [7:0] v);
    bytes_t r;
    logic [5:0] slot;
    r = a;
    slot = {1'b0, pos} + {3'b000, cnt} - 6'd1;
    if (cnt != 3'd0 && slot < 6'd16) begin
      r[slot[3:0]] = v;
    end
    return r;
  endfunction

  function automatic bytes_t commit_hex(bytes_t a, logic [4:0] pos, logic [15:0] v);
    bytes_t r;
    logic [3:0] b;
    r = a;
    b = pos[3:0];
    for (int k = 0; k < 16; k++) begin
      if (5'(k) >= pos && 6'(k) < {1'b0, pos} + 6'd4) begin
        r[k] = 8'd0;
      end
    end
    if (pos < 5'd15) begin
      r[b] = v[15:8];
      r[b + 4'd1] = v[7:0];
    end
    return r;
  endfunction

  // move bytes [e, i) to the tail and zero the opened gap
  function automatic bytes_t close_gap(bytes_t a, logic [4:0] e, logic [4:0] i);
    bytes_t r;
    logic [4:0] sh;
    logic [4:0] src;
    sh = BYTE_END - i;
    src = 5'd0;
    for (int k = 0; k < 16; k++) begin
      src = 5'(k) - sh;
      if (5'(k) < e) begin
        r[k] = a[k];
      end else if (6'(k) < {1'b0, e} + {1'b0, sh}) begin
        r[k] = 8'd0;
      end else begin
        r[k] = a[src[3:0]];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/ip_address_text_parser.sv */
// Top level: character-serial IPv6/IPv4 address text parser.
`default_nettype none

// Takes one ASCII character per item and returns the 128-bit address when a
// NUL character ends the string; other characters give no result. A
// character is accepted every cycle while no NUL is held back: it lands in an
// input register, and a parse step of up to two octet passes then updates the
// group, octet and address state, so the sustained rate is one character per
// clock under that condition. The result is formed from the NUL in the input
// register and sits in an output register; further characters keep flowing
// while it waits, only the next NUL holds. Hex groups, the '::' gap, dotted
// IPv4 tails with C-style octets, classful short forms and the 0xffff mark of
// plain IPv4 text are all handled; is_v6 reports whether a colon ended a group.
module ip_address_text_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  ch,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic [63:0]      addr_high,
  output logic [63:0]      addr_low,
  output logic             is_v6,
  output logic             out_valid,
  input  wire logic        out_ready
);
  import ipat_pkg::*;

  typedef enum logic [1:0] {PH_GROUP, PH_COLON, PH_V4, PH_SKIP} phase_t;
  typedef enum logic [2:0] {OP_START, OP_ZERO, OP_ZX, OP_DIGITS, OP_DONE} octet_phase_t;
  typedef enum logic [1:0] {RADIX_DEC, RADIX_OCT, RADIX_HEX} radix_t;

  logic [7:0]   ch_q;
  logic         q_valid;
  logic         go;

  bytes_t       addr_bytes, addr_bytes_next;
  logic [4:0]   byte_position, byte_position_next;
  logic [4:0]   gap_position, gap_position_next;
  logic         no_colon_seen, no_colon_seen_next;
  logic [15:0]  hex_accumulator, hex_accumulator_next;
  logic [4:0]   hex_digit_count, hex_digit_count_next;
  logic [7:0]   octet_accumulator, octet_accumulator_next;
  radix_t       octet_radix, octet_radix_next;
  logic [2:0]   octet_count, octet_count_next;
  phase_t       parse_phase, parse_phase_next;
  octet_phase_t octet_phase, octet_phase_next;

  logic         fire;
  logic [63:0]  result_high;
  logic [63:0]  result_low;
  logic         result_v6;

  assign go = q_valid && (ch_q != CH_NUL || !out_valid || out_ready);
  assign in_ready = !q_valid || go;

  always_comb begin
    logic [7:0] c;
    logic [4:0] hd;
    logic       cont;
    logic       feed;
    logic       done;
    logic       dotted;
    logic       ok;
    logic [7:0] mul;
    logic [4:0] ipos;
    logic [4:0] epos;
    logic [3:0] b;
    logic [1:0] cls;
    bytes_t     fb;

    c = ch_q;
    hd = hex_digit(c);
    cont = 1'b1;
    feed = 1'b0;
    done = 1'b0;
    dotted = 1'b0;
    ok = 1'b0;
    mul = 8'd0;
    ipos = 5'd0;
    epos = 5'd0;
    b = 4'd0;
    cls = 2'd0;
    fire = 1'b0;

    addr_bytes_next = addr_bytes;
    byte_position_next = byte_position;
    gap_position_next = gap_position;
    no_colon_seen_next = no_colon_seen;
    hex_accumulator_next = hex_accumulator;
    hex_digit_count_next = hex_digit_count;
    octet_accumulator_next = octet_accumulator;
    octet_radix_next = octet_radix;
    octet_count_next = octet_count;
    parse_phase_next = parse_phase;
    octet_phase_next = octet_phase;
    fb = addr_bytes;

    if (go) begin
      if (parse_phase == PH_COLON) begin
        hex_digit_count_next = 5'd0;
        parse_phase_next = (byte_position >= BYTE_END) ? PH_SKIP : PH_GROUP;
        if (c == CH_COLON) begin
          gap_position_next = byte_position;
          cont = 1'b0;
        end
      end

      if (cont) begin
        if (c == CH_NUL) begin
          fire = 1'b1;
          if (parse_phase_next == PH_V4) begin
            if (octet_phase_next == OP_ZX) octet_count_next = 3'd4;
            dotted = 1'b1;
          end else if (parse_phase_next == PH_GROUP && hex_digit_count_next != 5'd0) begin
            if (byte_position_next == 5'd0) begin
              if (octet_phase_next == OP_ZX) octet_count_next = 3'd4;
              dotted = 1'b1;
            end else begin
              addr_bytes_next = commit_hex(addr_bytes_next, byte_position_next,
                                           hex_accumulator_next);
              byte_position_next = byte_position_next + 5'd2;
            end
          end
        end else if (parse_phase_next == PH_SKIP) begin
          feed = 1'b0;
        end else if (parse_phase_next == PH_V4) begin
          feed = 1'b1;
        end else begin
          if (hex_digit_count_next == 5'd0) begin
            hex_accumulator_next = 16'd0;
            octet_phase_next = OP_START;
            octet_count_next = 3'd0;
            octet_accumulator_next = 8'd0;
            octet_radix_next = RADIX_DEC;
          end
          if (hd[4]) begin
            hex_accumulator_next = {hex_accumulator_next[11:0], hd[3:0]};
            if (hex_digit_count_next != HEX_COUNT_MAX) begin
              hex_digit_count_next = hex_digit_count_next + 5'd1;
            end
            feed = 1'b1;
          end else if (c == CH_DOT) begin
            if (byte_position_next >= 5'd14) begin
              addr_bytes_next[14] = 8'd0;
              addr_bytes_next[15] = 8'd0;
              byte_position_next = BYTE_END;
              parse_phase_next = PH_SKIP;
            end else begin
              feed = 1'b1;
              parse_phase_next = PH_V4;
            end
          end else begin
            addr_bytes_next = commit_hex(addr_bytes_next, byte_position_next,
                                         hex_accumulator_next);
            if (c == CH_COLON) begin
              byte_position_next = byte_position_next + 5'd2;
              no_colon_seen_next = 1'b0;
              parse_phase_next = PH_COLON;
            end else begin
              byte_position_next = BYTE_END;
              parse_phase_next = PH_SKIP;
            end
          end
        end
      end

      if (feed) begin
        for (int pass = 0; pass < 2; pass++) begin
          if (!done) begin
            cont = 1'b0;
            case (octet_phase_next)
              OP_START: begin
                done = 1'b1;
                if (octet_count_next >= 3'd4) begin
                  octet_phase_next = OP_DONE;
                end else begin
                  octet_count_next = octet_count_next + 3'd1;
                  octet_accumulator_next = 8'd0;
                  addr_bytes_next = store_octet(addr_bytes_next, byte_position_next,
                                                octet_count_next, octet_accumulator_next);
                  if (c == CH_DOT) begin
                    octet_phase_next = OP_START;
                  end else if (c == CH_ZERO) begin
                    octet_phase_next = OP_ZERO;
                  end else if (c >= CH_ONE && c <= CH_NINE) begin
                    octet_radix_next = RADIX_DEC;
                    octet_accumulator_next = {4'd0, hd[3:0]};
                    addr_bytes_next = store_octet(addr_bytes_next, byte_position_next,
                                                  octet_count_next, octet_accumulator_next);
                    octet_phase_next = OP_DIGITS;
                  end else begin
                    octet_count_next = 3'd4;
                    octet_phase_next = OP_DONE;
                  end
                end
              end
              OP_ZERO: begin
                if (c >= CH_ZERO && c <= CH_SEVEN) begin
                  octet_radix_next = RADIX_OCT;
                  octet_accumulator_next = {4'd0, hd[3:0]};
                  addr_bytes_next = store_octet(addr_bytes_next, byte_position_next,
                                                octet_count_next, octet_accumulator_next);
                  octet_phase_next = OP_DIGITS;
                  done = 1'b1;
                end else if (c == CH_X_LC || c == CH_X_UC) begin
                  octet_phase_next = OP_ZX;
                  done = 1'b1;
                end else begin
                  cont = 1'b1;
                end
              end
              OP_ZX: begin
                done = 1'b1;
                if (hd[4]) begin
                  octet_radix_next = RADIX_HEX;
                  octet_accumulator_next = {4'd0, hd[3:0]};
                  addr_bytes_next = store_octet(addr_bytes_next, byte_position_next,
                                                octet_count_next, octet_accumulator_next);
                  octet_phase_next = OP_DIGITS;
                end else begin
                  octet_count_next = 3'd4;
                  octet_phase_next = OP_DONE;
                end
              end
              OP_DIGITS: begin
                case (octet_radix_next)
                  RADIX_DEC: begin
                    ok = (c >= CH_ZERO && c <= CH_NINE);
                    mul = {octet_accumulator_next[4:0], 3'd0}
                        + {octet_accumulator_next[6:0], 1'b0};
                  end
                  RADIX_OCT: begin
                    ok = (c >= CH_ZERO && c <= CH_SEVEN);
                    mul = {octet_accumulator_next[4:0], 3'd0};
                  end
                  RADIX_HEX: begin
                    ok = hd[4];
                    mul = {octet_accumulator_next[3:0], 4'd0};
                  end
                  default: begin
                    ok = 1'b0;
                    mul = octet_accumulator_next;
                  end
                endcase
                if (ok) begin
                  octet_accumulator_next = mul + {4'd0, hd[3:0]};
                  addr_bytes_next = store_octet(addr_bytes_next, byte_position_next,
                                                octet_count_next, octet_accumulator_next);
                  done = 1'b1;
                end else begin
                  cont = 1'b1;
                end
              end
              default: begin
                done = 1'b1;
              end
            endcase
            if (cont) begin
              octet_phase_next = OP_START;
              if (c == CH_DOT) done = 1'b1;
            end
          end
        end
      end

      if (fire) begin
        fb = addr_bytes_next;
        ipos = byte_position_next;
        if (dotted && byte_position_next <= 5'd12) begin
          b = byte_position_next[3:0];
          cls = fb[b][7:6];
          if (cls[1] == 1'b0) begin
            if (octet_count_next == 3'd3) begin
              fb[b + 4'd3] = fb[b + 4'd2];
              fb[b + 4'd2] = fb[b + 4'd1];
              fb[b + 4'd1] = 8'd0;
            end else if (octet_count_next == 3'd2) begin
              fb[b + 4'd3] = fb[b + 4'd1];
              fb[b + 4'd1] = 8'd0;
            end
          end else if (cls == 2'd2 && octet_count_next == 3'd3) begin
            fb[b + 4'd3] = fb[b + 4'd2];
            fb[b + 4'd2] = 8'd0;
          end
          ipos = byte_position_next + 5'd4;
        end
        if (ipos < BYTE_END) begin
          epos = (gap_position_next > ipos) ? ipos : gap_position_next;
          fb = close_gap(fb, epos, ipos);
        end
        if (no_colon_seen_next) begin
          fb[10] = BYTE_ONES;
          fb[11] = BYTE_ONES;
        end

        for (int k = 0; k < 16; k++) addr_bytes_next[k] = 8'd0;
        byte_position_next = 5'd0;
        gap_position_next = 5'd0;
        no_colon_seen_next = 1'b1;
        hex_accumulator_next = 16'd0;
        hex_digit_count_next = 5'd0;
        octet_accumulator_next = 8'd0;
        octet_radix_next = RADIX_DEC;
        octet_count_next = 3'd0;
        parse_phase_next = PH_GROUP;
        octet_phase_next = OP_START;
      end
    end

    for (int k = 0; k < 8; k++) begin
      result_high[63 - 8 * k -: 8] = fb[k];
      result_low[63 - 8 * k -: 8] = fb[k + 8];
    end
    result_v6 = !no_colon_seen;
    if (fire) result_v6 = (no_colon_seen_next == 1'b0) ? 1'b1 : 1'b0;
    if (fire) result_v6 = !(parse_phase == PH_COLON) ? !no_colon_seen : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < 16; k++) addr_bytes[k] <= 8'd0;
      byte_position <= 5'd0;
      gap_position <= 5'd0;
      no_colon_seen <= 1'b1;
      hex_accumulator <= 16'd0;
      hex_digit_count <= 5'd0;
      octet_accumulator <= 8'd0;
      octet_radix <= RADIX_DEC;
      octet_count <= 3'd0;
      parse_phase <= PH_GROUP;
      octet_phase <= OP_START;
    end else begin
      if (in_valid && in_ready) begin
        q_valid <= 1'b1;
      end else if (go) begin
        q_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      addr_bytes <= addr_bytes_next;
      byte_position <= byte_position_next;
      gap_position <= gap_position_next;
      no_colon_seen <= no_colon_seen_next;
      hex_accumulator <= hex_accumulator_next;
      hex_digit_count <= hex_digit_count_next;
      octet_accumulator <= octet_accumulator_next;
      octet_radix <= octet_radix_next;
      octet_count <= octet_count_next;
      parse_phase <= parse_phase_next;
      octet_phase <= octet_phase_next;
    end
    if (in_valid && in_ready) begin
      ch_q <= ch;
    end
    if (fire) begin
      addr_high <= result_high;
      addr_low <= result_low;
      is_v6 <= result_v6;
    end
  end

endmodule

`default_nettype wire

/* test/tb_ip_address_text_parser.sv */
// Testbench for ip_address_text_parser: address strings checked against a character-level parser.
`timescale 1ns / 1ps

module tb_ip_address_text_parser;
  import ipat_pkg::*;

  localparam int ITEM_TARGET  = 850;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_START   = 400;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {SCAN_GROUP, SCAN_COLON, SCAN_DOTTED, SCAN_IGNORE} scan_t;
  typedef enum logic [2:0] {OCT_START, OCT_ZERO, OCT_ZX, OCT_DIGITS, OCT_DONE} oct_phase_t;
  typedef enum logic [1:0] {BASE_DEC, BASE_OCT, BASE_HEX} oct_base_t;
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        v6;
  } addr_t;

  typedef struct {
    string      txt;
    logic [7:0] tail;
    bit         pinned;
    addr_t      want;
  } row_t;

  localparam addr_t NONE = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  ch = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic        is_v6;
  logic        out_valid;
  logic        out_ready = 1'b0;

  bit    pin_now = 1'b0;
  addr_t pin_want = '0;

  addr_t      addr_expect_q [$];
  logic [7:0] text_q [$];
  int         err_count = 0;
  int         items_sent = 0;
  int         burst_left = 0;
  int         cycles = 0;

  row_t dir_rows [26] = '{
    '{"", CH_NUL, 1'b1, '{64'h0, 64'h0000_ffff_0000_0000, 1'b0}},
    '{"::", CH_NUL, 1'b1, '{64'h0, 64'h0, 1'b1}},
    '{"ffff:FFFF:ffff:ffff:ffff:ffff:ffff:ffff", CH_NUL, 1'b1,
      '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1}},
    '{"255.255.255.255", CH_NUL, 1'b1, '{64'h0, 64'h0000_ffff_ffff_ffff, 1'b0}},
    '{"0.0.0.0", CH_NUL, 1'b1, '{64'h0, 64'h0000_ffff_0000_0000, 1'b0}},
    '{"", 8'hff, 1'b1, '{64'h0, 64'h0000_ffff_0000_0000, 1'b0}},
    '{"1:g:2", CH_NUL, 1'b0, NONE},
    '{"1::", CH_NUL, 1'b0, NONE},
    '{"::ffff:192.168.1.1", CH_NUL, 1'b0, NONE},
    '{"1:2:3:4:5:6:7:1.2.3.4", CH_NUL, 1'b0, NONE},
    '{"1:2:3:4:5:6:7:8:9", CH_NUL, 1'b0, NONE},
    '{"1::2::3", CH_NUL, 1'b0, NONE},
    '{"12345:1", CH_NUL, 1'b0, NONE},
    '{"1:::2", CH_NUL, 1'b0, NONE},
    '{"123456789", CH_NUL, 1'b0, NONE},
    '{"0x7f.1", CH_NUL, 1'b0, NONE},
    '{"128.1.2", CH_NUL, 1'b0, NONE},
    '{"010.0X1f.9.0", CH_NUL, 1'b0, NONE},
    '{"089", CH_NUL, 1'b0, NONE},
    '{"12a", CH_NUL, 1'b0, NONE},
    '{"1.2.3.4.5", CH_NUL, 1'b0, NONE},
    '{"1.2.3.", CH_NUL, 1'b0, NONE},
    '{"1.2.x", CH_NUL, 1'b0, NONE},
    '{"0x.1", CH_NUL, 1'b0, NONE},
    '{"0x", CH_NUL, 1'b0, NONE},
    '{"fe80::1%eth0", CH_NUL, 1'b0, NONE}
  };

  ip_address_text_parser dut (
    .clk       (clk),
    .rst       (rst),
    .ch        (ch),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .addr_high (addr_high),
    .addr_low  (addr_low),
    .is_v6     (is_v6),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  always #1 clk = ~clk;

  // parser state
  logic [7:0]  abuf [16];
  int          bpos;
  int          gpos;
  bit          no_colon;
  logic [15:0] grp_val;
  int          grp_digits;
  logic [7:0]  oct_val;
  oct_base_t   oct_base;
  int          oct_num;
  scan_t       scan_ph;
  oct_phase_t  oct_ph;

  function automatic int hex_val_of(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_A_LC && c <= CH_F_LC) return int'(c - CH_A_LC) + 10;
    if (c >= CH_A_UC && c <= CH_F_UC) return int'(c - CH_A_UC) + 10;
    return -1;
  endfunction

  function automatic void scan_clear();
    foreach (abuf[k]) abuf[k] = 8'h00;
    bpos = 0;
    gpos = 0;
    no_colon = 1'b1;
    grp_val = '0;
    grp_digits = 0;
    oct_val = '0;
    oct_base = BASE_DEC;
    oct_num = 0;
    scan_ph = SCAN_GROUP;
    oct_ph = OCT_START;
  endfunction

  function automatic void oct_put();
    int slot;
    slot = bpos + oct_num - 1;
    if (oct_num != 0 && slot < 16) abuf[slot] = oct_val;
  endfunction

  function automatic void oct_digits(oct_base_t b, int d);
    oct_base = b;
    oct_val = 8'(d);
    oct_put();
    oct_ph = OCT_DIGITS;
  endfunction

  function automatic void oct_step(logic [7:0] c);
    int d;
    int base;
    bit ok;
    for (int pass = 0; pass < 2; pass++) begin
      d = hex_val_of(c);
      case (oct_ph)
        OCT_START: begin
          if (oct_num >= 4) begin
            oct_ph = OCT_DONE;
            return;
          end
          oct_num++;
          oct_val = '0;
          oct_put();
          if (c == CH_DOT) return;
          if (c == CH_ZERO) begin
            oct_ph = OCT_ZERO;
            return;
          end
          if (c >= CH_ONE && c <= CH_NINE) begin
            oct_digits(BASE_DEC, d);
            return;
          end
          oct_num = 4;
          oct_ph = OCT_DONE;
          return;
        end
        OCT_ZERO: begin
          if (c >= CH_ZERO && c <= CH_SEVEN) begin
            oct_digits(BASE_OCT, d);
            return;
          end
          if (c == CH_X_LC || c == CH_X_UC) begin
            oct_ph = OCT_ZX;
            return;
          end
        end
        OCT_ZX: begin
          if (d >= 0) begin
            oct_digits(BASE_HEX, d);
            return;
          end
          oct_num = 4;
          oct_ph = OCT_DONE;
          return;
        end
        OCT_DIGITS: begin
          base = 10;
          ok = (c >= CH_ZERO && c <= CH_NINE);
          if (oct_base == BASE_OCT) begin
            base = 8;
            ok = (c >= CH_ZERO && c <= CH_SEVEN);
          end else if (oct_base == BASE_HEX) begin
            base = 16;
            ok = (d >= 0);
          end
          if (ok) begin
            oct_val = 8'(int'(oct_val) * base + d);
            oct_put();
            return;
          end
        end
        default: return;
      endcase
      // octet ended: restart on this same character
      oct_ph = OCT_START;
      if (c == CH_DOT) return;
    end
  endfunction

  function automatic void grp_commit();
    for (int k = bpos; k < bpos + 4 && k < 16; k++) abuf[k] = 8'h00;
    if (bpos < 15) begin
      abuf[bpos] = grp_val[15:8];
      abuf[bpos + 1] = grp_val[7:0];
    end
  endfunction

  function automatic addr_t scan_close(bit dotted);
    int top;
    int e;
    logic [7:0] tmp [16];
    addr_t r;
    top = bpos;
    if (dotted && bpos <= 12) begin
      // spread classful short forms over the four octets
      if (abuf[bpos][7:6] < 2'd2) begin
        if (oct_num == 3) begin
          abuf[bpos + 3] = abuf[bpos + 2];
          abuf[bpos + 2] = abuf[bpos + 1];
          abuf[bpos + 1] = 8'h00;
        end else if (oct_num == 2) begin
          abuf[bpos + 3] = abuf[bpos + 1];
          abuf[bpos + 1] = 8'h00;
        end
      end else if (abuf[bpos][7:6] == 2'd2 && oct_num == 3) begin
        abuf[bpos + 3] = abuf[bpos + 2];
        abuf[bpos + 2] = 8'h00;
      end
      top = bpos + 4;
    end
    if (top < 16) begin
      e = (gpos > top) ? top : gpos;
      tmp = abuf;
      for (int k = 0; k < top - e; k++) abuf[e + 16 - top + k] = tmp[e + k];
      for (int k = e; k < e + 16 - top; k++) abuf[k] = 8'h00;
    end
    if (no_colon) begin
      abuf[10] = BYTE_ONES;
      abuf[11] = BYTE_ONES;
    end
    for (int k = 0; k < 8; k++) begin
      r.hi[63 - 8 * k -: 8] = abuf[k];
      r.lo[63 - 8 * k -: 8] = abuf[k + 8];
    end
    r.v6 = ~no_colon;
    scan_clear();
    return r;
  endfunction

  function automatic bit parse_char(logic [7:0] c, output addr_t r);
    int d;
    r = '0;
    if (scan_ph == SCAN_COLON) begin
      grp_digits = 0;
      scan_ph = (bpos >= 16) ? SCAN_IGNORE : SCAN_GROUP;
      if (c == CH_COLON) begin
        gpos = bpos;
        return 1'b0;
      end
    end
    if (c == CH_NUL) begin
      if (scan_ph == SCAN_DOTTED || (scan_ph == SCAN_GROUP && grp_digits != 0 && bpos == 0)) begin
        if (oct_ph == OCT_ZX) oct_num = 4;
        r = scan_close(1'b1);
        return 1'b1;
      end
      if (scan_ph == SCAN_GROUP && grp_digits != 0) begin
        grp_commit();
        bpos += 2;
      end
      r = scan_close(1'b0);
      return 1'b1;
    end
    if (scan_ph == SCAN_IGNORE) return 1'b0;
    if (scan_ph == SCAN_DOTTED) begin
      oct_step(c);
      return 1'b0;
    end
    if (grp_digits == 0) begin
      grp_val = '0;
      oct_ph = OCT_START;
      oct_num = 0;
      oct_val = '0;
      oct_base = BASE_DEC;
    end
    d = hex_val_of(c);
    if (d >= 0) begin
      grp_val = {grp_val[11:0], 4'(d)};
      if (grp_digits < 31) grp_digits++;
      oct_step(c);
      return 1'b0;
    end
    if (c == CH_DOT) begin
      if (bpos >= 14) begin
        abuf[14] = 8'h00;
        abuf[15] = 8'h00;
        bpos = 16;
        scan_ph = SCAN_IGNORE;
      end else begin
        oct_step(c);
        scan_ph = SCAN_DOTTED;
      end
      return 1'b0;
    end
    grp_commit();
    if (c == CH_COLON) begin
      bpos += 2;
      no_colon = 1'b0;
      scan_ph = SCAN_COLON;
    end else begin
      bpos = 16;
      scan_ph = SCAN_IGNORE;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    addr_t got;
    addr_t want;
    if (rst) begin
      scan_clear();
    end else begin
      if (out_valid && out_ready) begin
        if (addr_expect_q.size() == 0) begin
          $display("%0t: unexpected result hi %h lo %h v6 %b", $time, addr_high, addr_low, is_v6);
          err_count++;
        end else begin
          want = addr_expect_q.pop_front();
          if (addr_high !== want.hi) begin
            $display("%0t: addr_high expected %h actual %h", $time, want.hi, addr_high);
            err_count++;
          end
          if (addr_low !== want.lo) begin
            $display("%0t: addr_low expected %h actual %h", $time, want.lo, addr_low);
            err_count++;
          end
          if (is_v6 !== want.v6) begin
            $display("%0t: is_v6 expected %b actual %b", $time, want.v6, is_v6);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (parse_char(ch, got)) addr_expect_q.push_back(pin_now ? pin_want : got);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  int       rx_cycles = 0;
  int       rx_left = 0;
  rx_mode_t rx_mode = RX_FREE;

  always @(posedge clk) begin
    rx_cycles++;
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_CYCLES) begin
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= rx_cycles[2];
      endcase
    end
  end

  function automatic logic [7:0] hex_char(int d, bit up);
    if (d < 10) return CH_ZERO + 8'(d);
    return (up ? CH_A_UC : CH_A_LC) + 8'(d - 10);
  endfunction

  task automatic offer(logic [7:0] c, bit pin, addr_t want);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    ch <= c;
    pin_now <= pin;
    pin_want <= want;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_text(bit pin, addr_t want);
    foreach (text_q[k]) offer(text_q[k], 1'b0, NONE);
    offer(CH_NUL, pin, want);
    text_q.delete();
  endtask

  task automatic append_dotted(int n);
    string s;
    int v;
    for (int o = 0; o < n; o++) begin
      if (o > 0) text_q.push_back(CH_DOT);
      v = ($urandom_range(0, 15) == 0) ? $urandom_range(256, 4095) : $urandom_range(0, 255);
      case ($urandom_range(0, 3))
        0: s = $sformatf("%0d", v);
        1: s = $sformatf("0%0o", v);
        2: s = $sformatf("0x%0h", v);
        default: begin
          s = $sformatf("0X%0h", v);
          s = s.toupper();
        end
      endcase
      for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
    end
  endtask

  initial begin
    int start_count;
    int kind;
    int ng;
    int gap_at;
    int nd;
    bit up;
    string tricky;
    tricky = ".:0x9Xg7";
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].txt.len(); k++) text_q.push_back(dir_rows[r].txt[k]);
      if (dir_rows[r].tail != CH_NUL) text_q.push_back(dir_rows[r].tail);
      send_text(dir_rows[r].pinned, dir_rows[r].want);
    end

    start_count = items_sent;
    while (items_sent - start_count < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        ng = $urandom_range(1, 8);
        gap_at = ($urandom_range(0, 1) == 1) ? $urandom_range(0, ng) : -1;
        for (int g = 0; g < ng; g++) begin
          if (g == gap_at) begin
            text_q.push_back(CH_COLON);
            text_q.push_back(CH_COLON);
          end else if (g > 0) begin
            text_q.push_back(CH_COLON);
          end
          if (g == ng - 1 && $urandom_range(0, 3) == 0) begin
            append_dotted(4);
          end else begin
            nd = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
            up = 1'($urandom_range(0, 1));
            repeat (nd) text_q.push_back(hex_char($urandom_range(0, 15), up));
          end
        end
        if (gap_at == ng) begin
          text_q.push_back(CH_COLON);
          text_q.push_back(CH_COLON);
        end
      end else if (kind < 8) begin
        append_dotted($urandom_range(1, 5));
        if ($urandom_range(0, 7) == 0) text_q.push_back(CH_DOT);
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(1, 8)) text_q.push_back(tricky[$urandom_range(0, tricky.len() - 1)]);
      end
      // corrupt one character now and then
      if (text_q.size() != 0 && $urandom_range(0, 9) == 0) begin
        text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(1, 255));
      end
      send_text(1'b0, NONE);
    end
    in_valid <= 1'b0;

    while (addr_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && addr_expect_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
